/* sv/btl_pkg.sv */
// Shared types and codes for the bakery ticket lock.
`default_nettype none

package btl_pkg;

    // Request codes; the unused code behaves as a query.
    localparam logic [1:0] CMD_GET   = 2'd0;
    localparam logic [1:0] CMD_PUT   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Saturation value of the shared recursion count.
    localparam int unsigned REC_BITS = 16;
    localparam logic [REC_BITS-1:0] REC_MAX = {REC_BITS{1'b1}};

    // Result status codes.
    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_WAITING   = 3'd1,
        ST_RECURSIVE = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_REC_DEC   = 3'd4,
        ST_FULL      = 3'd5,
        ST_OVERFLOW  = 3'd6
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic rd_en;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* sv/bakery_ticket_lock_core.sv */
// Top level of the bakery ticket lock manager.
`default_nettype none

// Ticket lock manager: each get, put or query request produces one result
// transfer that reports the request status, the client's table slot and the
// current holder (lowest nonzero ticket, ties to the lower slot). A request is
// worked on in steps: the client table and the ticket store are walked one
// entry per cycle through their single read ports, then the read register is
// drained and the update is committed. The next request is taken as soon as
// the result has been loaded into the output register, even while that result
// still waits. A waiting result holds the commit of the next request until it
// leaves. All stores are empty after reset; no clearing pass is needed.
module bakery_ticket_lock_core #(
    parameter int MAX_CLIENTS = 16,
    parameter int TICKET_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] client_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [3:0]       client_slot,
    output logic             holder_valid,
    output logic [3:0]       holder_slot,
    output logic             locked
);
    import btl_pkg::*;

    ctrl_cmd_t                     cmd;
    dp_status_t                    dp_stat;
    logic [$clog2(MAX_CLIENTS)-1:0] rd_addr;

    // Sequencer.
    btl_ctrl #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .dp_stat  (dp_stat)
    );

    // Tables and result logic.
    btl_datapath #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .TICKET_BITS (TICKET_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .command      (command),
        .client_id    (client_id),
        .dp_stat      (dp_stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .client_slot  (client_slot),
        .holder_valid (holder_valid),
        .holder_slot  (holder_slot),
        .locked       (locked)
    );

endmodule

`default_nettype wire

/* sv/btl_ctrl.sv */
// Controller state machine that sequences the table scan and the commit.
`default_nettype none

module btl_ctrl #(
    parameter int MAX_CLIENTS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    output btl_pkg::ctrl_cmd_t                cmd,
    output logic [$clog2(MAX_CLIENTS)-1:0]    rd_addr,
    input  wire btl_pkg::dp_status_t          dp_stat
);
    import btl_pkg::*;

    localparam int IDX_W = $clog2(MAX_CLIENTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CLIENTS - 1);

    ctrl_state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // State and scan index registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        rd_addr    = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (dp_stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/btl_datapath.sv */
// Client table, ticket store, scan accumulators and result register.
`default_nettype none

module btl_datapath #(
    parameter int MAX_CLIENTS = 16,
    parameter int TICKET_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire btl_pkg::ctrl_cmd_t           cmd,
    input  wire logic [$clog2(MAX_CLIENTS)-1:0] rd_addr,
    input  wire logic [1:0]                   command,
    input  wire logic [31:0]                  client_id,
    output btl_pkg::dp_status_t               dp_stat,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [2:0]                        status,
    output logic [3:0]                        client_slot,
    output logic                              holder_valid,
    output logic [3:0]                        holder_slot,
    output logic                              locked
);
    import btl_pkg::*;

    localparam int IDX_W = $clog2(MAX_CLIENTS);
    localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_CLIENTS);
    localparam logic [TICKET_BITS-1:0] TICKET_MAX = {TICKET_BITS{1'b1}};

    // Storage.
    logic [31:0]          id_mem   [MAX_CLIENTS];
    logic [TICKET_BITS-1:0] tick_mem [MAX_CLIENTS];
    logic [MAX_CLIENTS-1:0] tick_vld_reg;
    logic [CNT_W-1:0]     id_count_reg;
    logic [REC_BITS-1:0]  rec_reg, rec_next;

    // Latched request.
    logic [1:0]  cmd_reg;
    logic [31:0] id_reg;

    // Read pipeline.
    logic [31:0]            id_rd_reg;
    logic [TICKET_BITS-1:0] tick_rd_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;

    // Scan accumulators.
    logic                   match_reg, match_next;
    logic [IDX_W-1:0]       mslot_reg, mslot_next;
    logic                   mnz_reg, mnz_next;
    logic [TICKET_BITS-1:0] max_reg, max_next;
    logic                   all_fnd_reg, all_fnd_next;
    logic [IDX_W-1:0]       all_slot_reg, all_slot_next;
    logic [TICKET_BITS-1:0] all_t_reg, all_t_next;
    logic                   exc_fnd_reg, exc_fnd_next;
    logic [IDX_W-1:0]       exc_slot_reg, exc_slot_next;
    logic [TICKET_BITS-1:0] exc_t_reg, exc_t_next;

    // Result register.
    logic             out_vld_reg;
    logic [2:0]       status_reg;
    logic [3:0]       cslot_reg;
    logic             hv_reg;
    logic [3:0]       hslot_reg;

    // Decision signals.
    logic                   is_match_now;
    logic [TICKET_BITS-1:0] tv;
    logic [IDX_W-1:0]       slot_sel;
    logic                   tbl_full;
    logic                   add_id;
    logic                   tick_we;
    logic [TICKET_BITS-1:0] tick_wdata;
    status_t                st_d;
    logic                   cslot_zero;
    logic                   hv_d;
    logic [IDX_W-1:0]       hs_d;
    logic [IDX_W+3:0]       cslot_ext;
    logic [IDX_W+3:0]       hslot_ext;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cmd_reg <= command;
            id_reg  <= client_id;
        end
    end

    // Memory writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && add_id)
        begin
            id_mem[slot_sel] <= id_reg;
        end
        if (cmd.commit && tick_we)
        begin
            tick_mem[slot_sel] <= tick_wdata;
        end
        if (cmd.rd_en)
        begin
            id_rd_reg   <= id_mem[rd_addr];
            tick_rd_reg <= tick_mem[rd_addr];
        end
    end

    // Read pipeline control and persistent state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            tick_vld_reg <= '0;
            id_count_reg <= '0;
            rec_reg      <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            rd_idx_reg <= rd_addr;
            if (cmd.commit)
            begin
                rec_reg <= rec_next;
                if (add_id)
                begin
                    id_count_reg <= id_count_reg + 1'b1;
                end
                if (tick_we)
                begin
                    tick_vld_reg[slot_sel] <= 1'b1;
                end
            end
        end
    end

    // Per-entry evaluation of the scan.
    always_comb
    begin
        tv            = tick_vld_reg[rd_idx_reg] ? tick_rd_reg : '0;
        is_match_now  = (CNT_W'(rd_idx_reg) < id_count_reg) && (id_rd_reg == id_reg);
        match_next    = match_reg;
        mslot_next    = mslot_reg;
        mnz_next      = mnz_reg;
        max_next      = max_reg;
        all_fnd_next  = all_fnd_reg;
        all_slot_next = all_slot_reg;
        all_t_next    = all_t_reg;
        exc_fnd_next  = exc_fnd_reg;
        exc_slot_next = exc_slot_reg;
        exc_t_next    = exc_t_reg;
        if (cmd.start)
        begin
            match_next   = 1'b0;
            mnz_next     = 1'b0;
            max_next     = '0;
            all_fnd_next = 1'b0;
            exc_fnd_next = 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (is_match_now)
            begin
                match_next = 1'b1;
                mslot_next = rd_idx_reg;
                mnz_next   = (tv != '0);
            end
            if (tv > max_reg)
            begin
                max_next = tv;
            end
            if ((tv != '0) && (!all_fnd_reg || (tv < all_t_reg)))
            begin
                all_fnd_next  = 1'b1;
                all_slot_next = rd_idx_reg;
                all_t_next    = tv;
            end
            if (!is_match_now && (tv != '0) && (!exc_fnd_reg || (tv < exc_t_reg)))
            begin
                exc_fnd_next  = 1'b1;
                exc_slot_next = rd_idx_reg;
                exc_t_next    = tv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg   <= 1'b0;
            mnz_reg     <= 1'b0;
            all_fnd_reg <= 1'b0;
            exc_fnd_reg <= 1'b0;
        end
        else
        begin
            match_reg   <= match_next;
            mnz_reg     <= mnz_next;
            all_fnd_reg <= all_fnd_next;
            exc_fnd_reg <= exc_fnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mslot_reg    <= mslot_next;
        max_reg      <= max_next;
        all_slot_reg <= all_slot_next;
        all_t_reg    <= all_t_next;
        exc_slot_reg <= exc_slot_next;
        exc_t_reg    <= exc_t_next;
    end

    // Request decision from the finished scan.
    always_comb
    begin
        slot_sel   = match_reg ? mslot_reg : id_count_reg[IDX_W-1:0];
        tbl_full   = !match_reg && (id_count_reg == FULL_CNT);
        add_id     = 1'b0;
        tick_we    = 1'b0;
        tick_wdata = '0;
        rec_next   = rec_reg;
        st_d       = ST_GRANTED;
        cslot_zero = 1'b1;
        hv_d       = all_fnd_reg;
        hs_d       = all_slot_reg;
        case (cmd_reg)
            CMD_GET:
            begin
                if (tbl_full)
                begin
                    st_d = ST_FULL;
                end
                else
                begin
                    add_id     = !match_reg;
                    cslot_zero = 1'b0;
                    if (match_reg && mnz_reg)
                    begin
                        if (rec_reg != REC_MAX)
                        begin
                            rec_next = rec_reg + 1'b1;
                        end
                        st_d = ST_RECURSIVE;
                    end
                    else if (max_reg == TICKET_MAX)
                    begin
                        st_d = ST_OVERFLOW;
                    end
                    else
                    begin
                        // The new ticket is above every other one.
                        tick_we    = 1'b1;
                        tick_wdata = max_reg + 1'b1;
                        if (all_fnd_reg)
                        begin
                            st_d = ST_WAITING;
                        end
                        else
                        begin
                            st_d = ST_GRANTED;
                            hv_d = 1'b1;
                            hs_d = slot_sel;
                        end
                    end
                end
            end
            CMD_PUT:
            begin
                if (tbl_full)
                begin
                    st_d = ST_FULL;
                end
                else
                begin
                    add_id     = !match_reg;
                    cslot_zero = 1'b0;
                    if (rec_reg != '0)
                    begin
                        rec_next = rec_reg - 1'b1;
                        st_d     = ST_REC_DEC;
                    end
                    else
                    begin
                        // The client's own ticket leaves the holder search.
                        tick_we    = 1'b1;
                        tick_wdata = '0;
                        st_d       = ST_RELEASED;
                        hv_d       = exc_fnd_reg;
                        hs_d       = exc_slot_reg;
                    end
                end
            end
            default:
            begin
                st_d = ST_GRANTED;
            end
        endcase
        cslot_ext = {4'b0000, (cslot_zero ? {IDX_W{1'b0}} : slot_sel)};
        hslot_ext = {4'b0000, (hv_d ? hs_d : {IDX_W{1'b0}})};
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= st_d;
            cslot_reg  <= cslot_ext[3:0];
            hv_reg     <= hv_d;
            hslot_reg  <= hslot_ext[3:0];
        end
    end

    assign dp_stat.out_free = !out_vld_reg || !out_stall;
    assign out_valid        = out_vld_reg;
    assign status           = status_reg;
    assign client_slot      = cslot_reg;
    assign holder_valid     = hv_reg;
    assign holder_slot      = hslot_reg;
    assign locked           = hv_reg;

endmodule

`default_nettype wire

/* sv/btl_checker.sv */
// Port-level checks of the bakery ticket lock and their binding.
`default_nettype none

module btl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [3:0]  client_slot,
    input wire logic        holder_valid,
    input wire logic [3:0]  holder_slot,
    input wire logic        locked
);
    import btl_pkg::*;

    // A request is worked on alone: the input stalls after each transfer.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in progress");

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(holder_slot) && $stable(client_slot))
        else $error("stalled result changed");

    // The lock flag and the holder flag agree.
    a_locked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> locked == holder_valid)
        else $error("locked differs from holder_valid");

    // A granted client is the holder.
    a_granted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_GRANTED && client_slot != 4'd0
            |-> holder_valid && holder_slot == client_slot)
        else $error("granted client is not the holder");

    // A full table reports slot zero.
    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> client_slot == 4'd0)
        else $error("table full result carries a slot");

endmodule

bind bakery_ticket_lock_core btl_checker u_btl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .client_slot  (client_slot),
    .holder_valid (holder_valid),
    .holder_slot  (holder_slot),
    .locked       (locked)
);

`default_nettype wire
